>>> hdl/mbdd_pkg.sv
// ----------------------------------------------------------------------------
// mbdd_pkg
// Types and constants shared by the multiplexed BCD display driver.
// ----------------------------------------------------------------------------
`default_nettype none

package mbdd_pkg;

  typedef enum logic [1:0] {
    KIND_TICK = 2'd0,
    KIND_SHOW = 2'd1,
    KIND_STOP = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    SCAN_STOPPED  = 2'd0,
    SCAN_HUNDREDS = 2'd1,
    SCAN_TENS     = 2'd2,
    SCAN_ONES     = 2'd3
  } scan_mode_e;

  localparam logic [9:0]  VALUE_MAX      = 10'd999;
  localparam logic [3:0]  ERROR_CODE     = 4'hE;
  localparam logic [9:0]  HUNDRED        = 10'd100;
  localparam logic [6:0]  TEN            = 7'd10;
  // Reciprocal factors: (u * 41) >> 12 is u / 100 for u <= 999, and
  // (r * 103) >> 10 is r / 10 for r <= 99.
  localparam logic [15:0] HUNDREDS_RECIP = 16'd41;
  localparam logic [13:0] TENS_RECIP     = 14'd103;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [10:0] value;
  } in_item_t;

  typedef struct packed {
    logic [3:0] hundreds;
    logic [3:0] tens;
    logic [3:0] ones;
  } digits_t;

endpackage

`default_nettype wire

>>> hdl/mbdd_in_if.sv
// ----------------------------------------------------------------------------
// mbdd_in_if
// Input channel of the display driver: command kind and value to show.
// ----------------------------------------------------------------------------
`default_nettype none

interface mbdd_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic signed [10:0] value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

`default_nettype wire

>>> hdl/mbdd_out_if.sv
// ----------------------------------------------------------------------------
// mbdd_out_if
// Output channel of the display driver: digit bus code and digit enables.
// ----------------------------------------------------------------------------
`default_nettype none

interface mbdd_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] digit_code;
  logic [2:0] digit_enable;

  modport source (output valid, output digit_code, output digit_enable, input ready);
  modport sink   (input valid, input digit_code, input digit_enable, output ready);
endinterface

`default_nettype wire

>>> hdl/mbdd_in_reg.sv
// ----------------------------------------------------------------------------
// mbdd_in_reg
// Input register stage. Takes a new transaction whenever it is empty or its
// current contents move on in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mbdd_in_reg
  import mbdd_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  mbdd_in_if.sink   in_i,
  input  wire logic advance_i,
  output logic      valid_o,
  output in_item_t  item_o
);

  logic     valid_q, valid_d;
  in_item_t item_q;
  logic     take;

  assign in_i.ready = !valid_q || advance_i;
  assign take       = in_i.valid && in_i.ready;
  assign valid_d    = take ? 1'b1 : (advance_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q.kind  <= in_i.kind;
      item_q.value <= in_i.value;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

>>> hdl/mbdd_bcd_split.sv
// ----------------------------------------------------------------------------
// mbdd_bcd_split
// Splits a signed value into hundreds, tens and ones, or the error code in
// all three digits when the value lies outside 0 to 999.
// ----------------------------------------------------------------------------
`default_nettype none

module mbdd_bcd_split
  import mbdd_pkg::*;
(
  input  wire logic signed [10:0] value_i,
  output digits_t                 digits_o
);

  logic [9:0]  mag;
  logic        in_range;
  logic [15:0] prod_h;
  logic [3:0]  hundreds;
  logic [6:0]  rem;
  logic [13:0] prod_t;
  logic [3:0]  tens;
  logic [3:0]  ones;

  assign mag      = value_i[9:0];
  assign in_range = !value_i[10] && (mag <= VALUE_MAX);

  assign prod_h   = {6'd0, mag} * HUNDREDS_RECIP;
  assign hundreds = prod_h[15:12];
  assign rem      = 7'(mag - {6'd0, hundreds} * HUNDRED);
  assign prod_t   = {7'd0, rem} * TENS_RECIP;
  assign tens     = prod_t[13:10];
  assign ones     = 4'(rem - {3'd0, tens} * TEN);

  always_comb begin
    if (in_range) begin
      digits_o = '{hundreds: hundreds, tens: tens, ones: ones};
    end else begin
      digits_o = '{hundreds: ERROR_CODE, tens: ERROR_CODE, ones: ERROR_CODE};
    end
  end

endmodule

`default_nettype wire

>>> hdl/mbdd_scan.sv
// ----------------------------------------------------------------------------
// mbdd_scan
// Scan sequencer, digit store and result register. Each transaction from the
// input register updates the state and loads the result register; only a tick changes the bus code and enables.
// ----------------------------------------------------------------------------
`default_nettype none

module mbdd_scan
  import mbdd_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic valid_i,
  input  in_item_t  item_i,
  input  digits_t   split_i,
  output logic      advance_o,
  mbdd_out_if.source out_o
);

  scan_mode_e mode_q, mode_d;
  digits_t    store_q, store_d;
  logic [3:0] code_q, code_d;
  logic [2:0] enable_q, enable_d;
  logic       out_valid_q, out_valid_d;
  logic       fire;

  assign advance_o   = !out_valid_q || out_o.ready;
  assign fire        = valid_i && advance_o;
  assign out_valid_d = fire ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= SCAN_STOPPED;
      store_q     <= '0;
      code_q      <= '0;
      enable_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mode_q      <= mode_d;
      store_q     <= store_d;
      code_q      <= code_d;
      enable_q    <= enable_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    mode_d   = mode_q;
    store_d  = store_q;
    code_d   = code_q;
    enable_d = enable_q;
    if (fire) begin
      case (kind_e'(item_i.kind))
        KIND_SHOW: begin
          store_d = split_i;
          mode_d  = SCAN_HUNDREDS;
        end
        KIND_STOP: begin
          mode_d = SCAN_STOPPED;
        end
        KIND_TICK: begin
          // Every tick rewrites all three enables, so at most one digit is lit.
          case (mode_q)
            SCAN_HUNDREDS: begin
              code_d   = store_q.hundreds;
              enable_d = 3'b001;
              mode_d   = SCAN_TENS;
            end
            SCAN_TENS: begin
              code_d   = store_q.tens;
              enable_d = 3'b010;
              mode_d   = SCAN_ONES;
            end
            SCAN_ONES: begin
              code_d   = store_q.ones;
              enable_d = 3'b100;
              mode_d   = SCAN_HUNDREDS;
            end
            default: begin
              enable_d = 3'b000;
            end
          endcase
        end
        default: begin
          mode_d = mode_q;
        end
      endcase
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.digit_code   = code_q;
  assign out_o.digit_enable = enable_q;

endmodule

`default_nettype wire

>>> hdl/multiplexed_bcd_display_driver.sv
// ----------------------------------------------------------------------------
// multiplexed_bcd_display_driver
// Three-digit multiplexed BCD display driver with one result per command.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock cycle on in_i while out_o is not
// stalled, and returns exactly one transaction on out_o for each, carrying the
// bus code and the digit enables as they stand after that command. A command
// is held in the input register, then the digit split and scan logic load the
// result register, which presents it on out_o. When out_o is stalled the result
// register holds and the input register fills, after which in_i deasserts ready
// until the result is taken.
`default_nettype none

module multiplexed_bcd_display_driver
  import mbdd_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  mbdd_in_if.sink     in_i,
  mbdd_out_if.source  out_o
);

  logic     s1_valid;
  in_item_t s1_item;
  digits_t  split;
  logic     advance;

  mbdd_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .advance_i (advance),
    .valid_o   (s1_valid),
    .item_o    (s1_item)
  );

  mbdd_bcd_split u_split (
    .value_i  (s1_item.value),
    .digits_o (split)
  );

  mbdd_scan u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s1_valid),
    .item_i    (s1_item),
    .split_i   (split),
    .advance_o (advance),
    .out_o     (out_o)
  );

endmodule

`default_nettype wire

>>> hdl/mbdd_checker.sv
// ----------------------------------------------------------------------------
// mbdd_checker
// Port-level checks on the display driver, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mbdd_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_i,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [3:0] out_code_i,
  input wire logic [2:0] out_enable_i
);

  // Never more than one digit lit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> $onehot0(out_enable_i))
    else $error("more than one digit enable is set");

  // The input side only stalls behind a result that is waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> (out_valid_i && !out_ready_i))
    else $error("input stalled without a waiting result");

  // A result after an empty spell comes from an input transaction that passed straight through the input register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2))
    else $error("result without a matching input transaction");

  // A stalled result keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(out_code_i) && $stable(out_enable_i)))
    else $error("stalled result changed");

endmodule

bind multiplexed_bcd_display_driver mbdd_checker u_mbdd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_code_i   (out_o.digit_code),
  .out_enable_i (out_o.digit_enable)
);

`default_nettype wire

>>> tb/sv/multiplexed_bcd_display_driver_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multiplexed_bcd_display_driver_checker
// Watches both channels of the display driver, predicts the bus state after
// every accepted command and compares it with each returned transaction.
// ----------------------------------------------------------------------------

module multiplexed_bcd_display_driver_checker
  import mbdd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  mbdd_in_if         in_mon,
  mbdd_out_if        out_mon,
  output int         fail_count_o,
  output int         pending_o
);

  typedef struct packed {
    logic [3:0] code;
    logic [2:0] enable;
  } bus_state_t;

  scan_mode_e   scan_mode;
  logic [3:0]   digit_codes [3];
  logic [3:0]   bus_code;
  logic [2:0]   bus_enable;
  bus_state_t   bus_state_q [$];

  // Applies one command to the mirrored display state and returns the bus.
  function automatic bus_state_t advance_display(logic [1:0] kind,
                                                 logic signed [10:0] value);
    int unsigned number;
    int unsigned slot;
    bus_state_t  bus;
    case (kind)
      KIND_SHOW: begin
        if (!value[10] && value[9:0] <= VALUE_MAX) begin
          number         = value[9:0];
          digit_codes[0] = 4'(number / 100);
          digit_codes[1] = 4'((number / 10) % 10);
          digit_codes[2] = 4'(number % 10);
        end else begin
          digit_codes[0] = ERROR_CODE;
          digit_codes[1] = ERROR_CODE;
          digit_codes[2] = ERROR_CODE;
        end
        scan_mode = SCAN_HUNDREDS;
      end
      KIND_STOP: begin
        scan_mode = SCAN_STOPPED;
      end
      KIND_TICK: begin
        if (scan_mode == SCAN_STOPPED) begin
          bus_enable = 3'b000;
        end else begin
          slot       = int'(scan_mode) - 1;
          bus_code   = digit_codes[slot];
          bus_enable = 3'b001 << slot;
          scan_mode  = (scan_mode == SCAN_ONES) ? SCAN_HUNDREDS
                                                : scan_mode_e'(scan_mode + 2'd1);
        end
      end
      default: begin
      end
    endcase
    bus.code   = bus_code;
    bus.enable = bus_enable;
    return bus;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    bus_state_t want;
    if (!rst_ni) begin
      scan_mode      = SCAN_STOPPED;
      digit_codes[0] = 4'd0;
      digit_codes[1] = 4'd0;
      digit_codes[2] = 4'd0;
      bus_code       = 4'd0;
      bus_enable     = 3'd0;
      bus_state_q.delete();
      fail_count_o   = 0;
      pending_o      = 0;
    end else begin
      // The oldest result leaves before this edge's command is predicted.
      if (out_mon.valid && out_mon.ready) begin
        if (bus_state_q.size() == 0) begin
          $display("%0t: result transaction with none expected: code %h enable %b",
                   $time, out_mon.digit_code, out_mon.digit_enable);
          fail_count_o++;
        end else begin
          want = bus_state_q.pop_front();
          if (out_mon.digit_code !== want.code) begin
            $display("%0t: digit_code mismatch: expected %h actual %h",
                     $time, want.code, out_mon.digit_code);
            fail_count_o++;
          end
          if (out_mon.digit_enable !== want.enable) begin
            $display("%0t: digit_enable mismatch: expected %b actual %b",
                     $time, want.enable, out_mon.digit_enable);
            fail_count_o++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        bus_state_q.push_back(advance_display(in_mon.kind, in_mon.value));
      end
      pending_o = bus_state_q.size();
    end
  end

endmodule

>>> tb/sv/multiplexed_bcd_display_driver_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multiplexed_bcd_display_driver_tb
// Drives show, stop and tick commands into the display driver under varying
// idle and stall patterns; the checker beside the block judges every result.
// ----------------------------------------------------------------------------

module multiplexed_bcd_display_driver_tb;
  import mbdd_pkg::*;

  localparam int PHASE_ITEMS      = 270;
  localparam int LONG_HOLD_CYCLES = 200;
  localparam int STALL_LIMIT      = 5000;
  localparam int DRAIN_CYCLES     = 10;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  int          fail_count;
  int          pending;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  bit          hold_go       = 1'b0;
  int          quiet_cycles  = 0;

  mbdd_in_if  in_bus ();
  mbdd_out_if out_bus ();

  multiplexed_bcd_display_driver u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  multiplexed_bcd_display_driver_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_bus),
    .out_mon      (out_bus),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Offers one command from a falling edge and returns at the falling edge
  // after its transaction.
  task automatic send_item(input kind_e kind, input logic signed [10:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_bus.valid <= 1'b1;
    in_bus.kind  <= kind;
    in_bus.value <= value;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Mostly displayable numbers, with out-of-range ones mixed in.
  function automatic logic signed [10:0] random_value();
    if ($urandom_range(9) < 7) begin
      return 11'($urandom_range(999));
    end
    return 11'($urandom_range(2047));
  endfunction

  task automatic send_random_item();
    int unsigned pick;
    logic signed [10:0] value;
    pick  = $urandom_range(99);
    value = random_value();
    if (pick < 14) begin
      send_item(KIND_SHOW, value);
    end else if (pick < 19) begin
      send_item(KIND_STOP, value);
    end else begin
      send_item(KIND_TICK, value);
    end
  endtask

  task automatic wait_for_drain();
    in_bus.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    int hold_left;
    bit hold_done;
    hold_left     = 0;
    hold_done     = 1'b0;
    out_bus.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    in_bus.valid = 1'b0;
    in_bus.kind  = KIND_TICK;
    in_bus.value = 11'sd0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed commands: blanking while stopped, digit extremes, error codes,
    // a stop taking effect at the next tick and restarts in the middle of a scan.
    send_item(KIND_TICK, 11'sd0);
    send_item(KIND_SHOW, 11'sd0);
    send_item(KIND_TICK, 11'sh7FF);
    send_item(KIND_TICK, 11'sh400);
    send_item(KIND_TICK, 11'sd0);
    send_item(KIND_SHOW, 11'sd999);
    send_item(KIND_TICK, 11'sd0);
    send_item(KIND_TICK, 11'sd0);
    send_item(KIND_TICK, 11'sd0);
    send_item(KIND_TICK, 11'sd0);
    send_item(KIND_SHOW, 11'sd1000);
    send_item(KIND_TICK, 11'sd0);
    send_item(KIND_SHOW, 11'sh7FF);
    send_item(KIND_TICK, 11'sd0);
    send_item(KIND_SHOW, 11'sh400);
    send_item(KIND_SHOW, 11'sd1023);
    send_item(KIND_STOP, 11'sd0);
    send_item(KIND_TICK, 11'sd0);
    send_item(KIND_SHOW, 11'sd512);
    send_item(KIND_TICK, 11'sd0);
    send_item(KIND_TICK, 11'sd0);
    send_item(KIND_SHOW, 11'sd123);
    send_item(KIND_TICK, 11'sd0);
    send_item(KIND_STOP, 11'sd0);
    send_item(KIND_TICK, 11'sd0);
    wait_for_drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 87; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 87; end
        default: begin send_idle_pct = 18; stall_pct = 18; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // The result side holds off while commands keep coming, so that the
        // block fills and has to refuse input.
        if (phase == 0 && n == 40) begin
          hold_go = 1'b1;
        end
        send_random_item();
      end
      wait_for_drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
